// ===== hdl/tccs_pkg.sv =====
// Package for the text console block: screen geometry, field widths,
// command codes and word layout. Used by text_console_cursor_scroll.
// No dependencies.
package tccs_pkg;

  // Screen store geometry
  localparam int MAX_COLS   = 80;
  localparam int MAX_ROWS   = 25;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);

  // Field widths
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int MODE_W = 2;

  // Register reset values
  localparam logic [COL_W-1:0] COLS_RESET = COL_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(MAX_ROWS);

  // Register indexes
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_PRINT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Special bytes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

  // Stream word widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

endpackage

// ===== hdl/text_console_cursor_scroll.sv =====
// Sequence: a command word is normalised, executed and its result word registered; a
// read waits for the store's data, a print into a blank row first sweeps zeros through
// it, and the top row is reduced modulo the rows in use. One command word at a time,
// set by the read-modify-write sequencer around the single screen store; a stalled result word holds the input.
// Reset: synchronous; cursor, top row and per-row valid flags cleared at once.
// Console with screen store, cursor and scroll; depends on tccs_pkg and tccs_ram.
module text_console_cursor_scroll (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata,
  // command words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], col[14:8], row[19:15]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // read_data[7:0], cursor_col[14:8],
                                  // cursor_row[19:15], scrolled[20]
);

  localparam int COL_W  = tccs_pkg::COL_W;
  localparam int ROW_W  = tccs_pkg::ROW_W;
  localparam int CHAR_W = tccs_pkg::CHAR_W;
  localparam int ADDR_W = tccs_pkg::ADDR_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [COL_W-1:0]            cols_r;
  logic [ROW_W-1:0]            rows_r;
  logic [COL_W-1:0]            cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]            cur_y_r, cur_y_nxt;
  logic [ROW_W-1:0]            top_r, top_nxt;
  logic [ROW_W-1:0]            t_r, t_nxt;
  logic [tccs_pkg::MAX_ROWS-1:0] row_vld_r, row_vld_nxt;
  logic [ROW_W-1:0]            p_r, p_nxt;
  logic [COL_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [tccs_pkg::MODE_W-1:0] mode_r;
  logic [CHAR_W-1:0]           ch_r;
  logic [COL_W-1:0]            col_r;
  logic [ROW_W-1:0]            row_r;
  logic [CHAR_W-1:0]           res_rd_r, res_rd_nxt;
  logic                        scr_r, scr_nxt;
  logic                        out_tvalid_r;
  logic [23:0]                 out_tdata_r;

  logic [COL_W-1:0]  cols_eff;
  logic [ROW_W-1:0]  rows_eff;
  logic              in_acc;
  logic [ROW_W-1:0]  sel_row;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys;
  logic [COL_W-1:0]  sel_col;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] clr_addr;
  logic [ROW_W:0]    y_inc;
  logic [COL_W:0]    x_inc;
  logic [ROW_W:0]    t_inc;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;
  logic              out_free;

  // effective screen size, saturated into range
  always_comb begin
    if (cols_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (cols_r > COL_W'(tccs_pkg::MAX_COLS)) begin
      cols_eff = COL_W'(tccs_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_r;
    end
    if (rows_r == '0) begin
      rows_eff = ROW_W'(1);
    end else if (rows_r > ROW_W'(tccs_pkg::MAX_ROWS)) begin
      rows_eff = ROW_W'(tccs_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_r;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // physical row and cell address; t_r is below rows_eff, and so is sel_row whenever the address is used
  assign sel_row  = (mode_r == tccs_pkg::MODE_READ) ? row_r : cur_y_r;
  assign sel_col  = (mode_r == tccs_pkg::MODE_READ) ? col_r : cur_x_r;
  assign row_sum  = {1'b0, t_r} + {1'b0, sel_row};
  assign phys     = (row_sum >= {1'b0, rows_eff}) ? ROW_W'(row_sum - {1'b0, rows_eff})
                                                  : ROW_W'(row_sum);
  assign cell_addr = ADDR_W'(ADDR_W'(phys) * ADDR_W'(tccs_pkg::MAX_COLS)) + ADDR_W'(sel_col);
  assign clr_addr  = ADDR_W'(ADDR_W'(p_r) * ADDR_W'(tccs_pkg::MAX_COLS))
                   + ADDR_W'(clr_cnt_r);
  assign y_inc    = {1'b0, cur_y_r} + (ROW_W+1)'(1);
  assign x_inc    = {1'b0, cur_x_r} + (COL_W+1)'(1);
  assign t_inc    = {1'b0, t_r} + (ROW_W+1)'(1);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    top_nxt     = top_r;
    t_nxt       = t_r;
    row_vld_nxt = row_vld_r;
    p_nxt       = p_r;
    clr_cnt_nxt = clr_cnt_r;
    res_rd_nxt  = res_rd_r;
    scr_nxt     = scr_r;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr;
    ram_wdata   = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // stale cursor is pulled into the screen first
          if (cur_x_r >= cols_eff) cur_x_nxt = cols_eff - COL_W'(1);
          if (cur_y_r >= rows_eff) cur_y_nxt = rows_eff - ROW_W'(1);
          t_nxt      = top_r;
          res_rd_nxt = '0;
          scr_nxt    = 1'b0;
          state_nxt  = ST_NORM;
        end
      end
      ST_NORM: begin
        // reduce top row modulo rows, one subtraction a cycle
        if (t_r >= rows_eff) begin
          t_nxt = t_r - rows_eff;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        p_nxt     = phys;
        state_nxt = ST_DONE;
        case (mode_r)
          tccs_pkg::MODE_PRINT: begin
            if (ch_r == tccs_pkg::CH_NEWLINE || ch_r != tccs_pkg::CH_NUL) begin
              if (ch_r != tccs_pkg::CH_NEWLINE && !row_vld_r[phys]) begin
                // blank row: sweep zeros through it before the write
                clr_cnt_nxt = '0;
                state_nxt   = ST_CLR;
              end else begin
                if (ch_r != tccs_pkg::CH_NEWLINE) begin
                  ram_we    = 1'b1;
                  cur_x_nxt = COL_W'(x_inc);
                end
                if (ch_r == tccs_pkg::CH_NEWLINE || x_inc >= {1'b0, cols_eff}) begin
                  cur_x_nxt = '0;
                  if (y_inc >= {1'b0, rows_eff}) begin
                    // scroll: old top row becomes the blank bottom row
                    cur_y_nxt      = rows_eff - ROW_W'(1);
                    top_nxt        = (t_inc == {1'b0, rows_eff}) ? '0 : ROW_W'(t_inc);
                    row_vld_nxt[t_r] = 1'b0;
                    scr_nxt        = 1'b1;
                  end else begin
                    cur_y_nxt = ROW_W'(y_inc);
                  end
                end
              end
            end
          end
          tccs_pkg::MODE_MOVE: begin
            cur_x_nxt = (col_r < cols_eff) ? col_r : cols_eff - COL_W'(1);
            cur_y_nxt = (row_r < rows_eff) ? row_r : rows_eff - ROW_W'(1);
          end
          tccs_pkg::MODE_CLEAR: begin
            row_vld_nxt = '0;
            cur_x_nxt   = '0;
            cur_y_nxt   = '0;
            top_nxt     = '0;
          end
          default: begin
            // read: address goes to the store now, data next cycle
            if (col_r < cols_eff && row_r < rows_eff) state_nxt = ST_RD;
          end
        endcase
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_cnt_r == COL_W'(tccs_pkg::MAX_COLS - 1)) begin
          row_vld_nxt[p_r] = 1'b1;
          state_nxt        = ST_EXEC;
        end else begin
          clr_cnt_nxt = clr_cnt_r + COL_W'(1);
        end
      end
      ST_RD: begin
        res_rd_nxt = row_vld_r[p_r] ? ram_rdata : '0;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cols_r       <= tccs_pkg::COLS_RESET;
      rows_r       <= tccs_pkg::ROWS_RESET;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      top_r        <= '0;
      row_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      top_r     <= top_nxt;
      row_vld_r <= row_vld_nxt;
      if (cfg_we) begin
        if (cfg_index == tccs_pkg::CFG_COLS) begin
          cols_r <= cfg_wdata;
        end else begin
          rows_r <= cfg_wdata[ROW_W-1:0];
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    p_r       <= p_nxt;
    clr_cnt_r <= clr_cnt_nxt;
    res_rd_r  <= res_rd_nxt;
    scr_r     <= scr_nxt;
    if (in_acc) begin
      mode_r <= in_tuser;
      ch_r   <= in_tdata[7:0];
      col_r  <= in_tdata[14:8];
      row_r  <= in_tdata[19:15];
    end
    if (state_r == ST_DONE && out_free) begin
      out_tdata_r <= {3'b000, scr_r, cur_y_r, cur_x_r, res_rd_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // screen store
  tccs_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(tccs_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cell_addr),
    .rdata(ram_rdata)
  );

  // checks
  a_sweep_row_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !row_vld_r[p_r])
    else $error("row under sweep already marked valid");

  a_store_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_EXEC || state_r == ST_CLR))
    else $error("store written outside print or sweep");

  a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r < ROW_W'(tccs_pkg::MAX_ROWS))
    else $error("top row beyond store");

  a_scroll_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && scr_r) |-> (cur_x_r == '0))
    else $error("scroll left cursor off column zero");

endmodule

// ===== hdl/tccs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
